// ----- hdl/jfs_pkg.sv -----
// Shared types and constants for the JPEG frame size scanner.
// Used by the parser, the result register and the top level; no dependencies.
`default_nettype none

package jfs_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_NO_SOI    = 3'd1,
        ST_STRAY     = 3'd2,
        ST_SOI_EOI   = 3'd3,
        ST_SOF_LEN   = 3'd4,
        ST_SEG_SHORT = 3'd5,
        ST_TRUNC     = 3'd6
    } jfs_status_t;

    typedef struct packed {
        logic [15:0] discarded_count;
        logic [15:0] height;
        logic [15:0] width;
        jfs_status_t status;
    } jfs_result_t;

endpackage

`default_nettype wire

// ----- hdl/jpeg_frame_size_scanner_core.sv -----
// JPEG frame size scanner: takes a JPEG file one byte per word and reports
// one verdict per file, with the frame width and height when an SOF is found.
// One byte is accepted every clock cycle, since each byte costs a single state
// update of the parser. A verdict is registered and reaches the result channel
// at the earliest in the cycle after the byte that decides it. One verdict can
// wait behind a stalled one in a skid register; only while that register is
// full is the input held off, and s_tready comes straight from a register.
// Depends on jfs_pkg, jfs_parser and jfs_out_reg.
`default_nettype none

module jpeg_frame_size_scanner_core #(
    parameter int COUNT_BITS = jfs_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,     // allow_stray
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] byte_value
    input  wire logic        s_tuser,      // [0] first_byte
    input  wire logic        s_tlast,      // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,      // [15:0] width, [31:16] height,
                                           // [47:32] discarded_count
    output logic [2:0]       m_tuser       // [2:0] status
);
    import jfs_pkg::*;

    logic        step;
    logic        res_valid;
    jfs_result_t res;
    jfs_result_t out_res;

    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;

    jfs_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_allow_stray(cfg_data),
        .step           (step),
        .byte_value     (s_tdata),
        .first_byte     (s_tuser),
        .last_byte      (s_tlast),
        .res_valid      (res_valid),
        .res            (res)
    );

    jfs_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && res_valid),
        .load_res  (res),
        .can_accept(s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.discarded_count, out_res.height, out_res.width};
    assign m_tuser = out_res.status;

`ifndef SYNTH
    a_first_last_gives_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast && s_tuser |=> m_tvalid)
        else $error("A one-byte file produced no verdict.");

    a_error_has_no_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata[31:0] == 32'd0))
        else $error("An error verdict carries a nonzero frame size.");

    a_status_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_TRUNC))
        else $error("Verdict status code is out of range.");
`endif

endmodule

`default_nettype wire

// ----- hdl/jfs_parser.sv -----
// Byte-wise marker parser: updates the parse state for each accepted word and
// forms the verdict of that word. Depends on jfs_pkg.
`default_nettype none

module jfs_parser #(
    parameter int COUNT_BITS = jfs_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_allow_stray,
    input  wire logic               step,
    input  wire logic [7:0]         byte_value,
    input  wire logic               first_byte,
    input  wire logic               last_byte,
    output logic                    res_valid,
    output jfs_pkg::jfs_result_t    res
);
    import jfs_pkg::*;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;
    localparam int WIDE_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [2:0] {
        PH_SOI0, PH_SOI1, PH_HUNT, PH_FILL, PH_SOFH, PH_SLEN, PH_SKIP
    } phase_t;

    phase_t                  phase_reg, phase_next, cur_phase;
    logic [2:0]              index_reg, index_next, cur_index;
    logic [15:0]             skip_reg, skip_next, cur_skip;
    logic [15:0]             seglen_reg, seglen_next, cur_seglen;
    logic [15:0]             height_reg, height_next, cur_height;
    logic [15:0]             width_reg, width_next, cur_width;
    logic [COUNT_BITS-1:0]   stray_reg, stray_next, cur_stray;
    logic                    verdict_reg, verdict_next, cur_verdict;
    logic                    allow_stray_reg;
    logic                    hit;
    jfs_status_t             status;
    logic [15:0]             full_len;
    logic [9:0]              sof_len;
    logic                    frame_marker;
    logic [WIDE_BITS-1:0]    stray_wide;

    assign frame_marker = (byte_value[7:4] == 4'hC) && (byte_value[3:0] != 4'h4)
                          && (byte_value[3:0] != 4'h8) && (byte_value[3:0] != 4'hC);
    assign full_len = {cur_seglen[15:8], byte_value};
    assign sof_len  = 10'd8 + {1'b0, byte_value, 1'b0} + {2'b00, byte_value};

    always_comb begin
        cur_phase   = first_byte ? PH_SOI0 : phase_reg;
        cur_index   = first_byte ? 3'd0 : index_reg;
        cur_skip    = first_byte ? 16'd0 : skip_reg;
        cur_seglen  = first_byte ? 16'd0 : seglen_reg;
        cur_height  = first_byte ? 16'd0 : height_reg;
        cur_width   = first_byte ? 16'd0 : width_reg;
        cur_stray   = first_byte ? '0 : stray_reg;
        cur_verdict = first_byte ? 1'b0 : verdict_reg;

        phase_next   = cur_phase;
        index_next   = cur_index;
        skip_next    = cur_skip;
        seglen_next  = cur_seglen;
        height_next  = cur_height;
        width_next   = cur_width;
        stray_next   = cur_stray;
        verdict_next = cur_verdict;
        hit          = 1'b0;
        status       = ST_FOUND;

        if (!cur_verdict) begin
            unique case (cur_phase)
                PH_SOI0: begin
                    index_next = (byte_value != BYTE_FF) ? 3'd1 : 3'd0;
                    phase_next = PH_SOI1;
                end
                PH_SOI1: begin
                    if (cur_index != 3'd0 || byte_value != BYTE_SOI) begin
                        hit    = 1'b1;
                        status = ST_NO_SOI;
                    end else begin
                        index_next = 3'd0;
                        phase_next = PH_HUNT;
                    end
                end
                PH_HUNT: begin
                    if (byte_value == BYTE_FF) begin
                        phase_next = PH_FILL;
                    end else if (allow_stray_reg) begin
                        if (cur_stray != '1) begin
                            stray_next = cur_stray + 1'b1;
                        end
                    end else begin
                        hit    = 1'b1;
                        status = ST_STRAY;
                    end
                end
                PH_FILL: begin
                    if (byte_value != BYTE_FF) begin
                        index_next = 3'd0;
                        if (frame_marker) begin
                            phase_next = PH_SOFH;
                        end else if (byte_value == BYTE_SOI || byte_value == BYTE_EOI) begin
                            hit    = 1'b1;
                            status = ST_SOI_EOI;
                        end else begin
                            phase_next = PH_SLEN;
                        end
                    end
                end
                PH_SOFH: begin
                    index_next = cur_index + 3'd1;
                    case (cur_index)
                        3'd0: seglen_next = {byte_value, 8'h00};
                        3'd1: seglen_next = {cur_seglen[15:8], byte_value};
                        3'd3: height_next = {byte_value, 8'h00};
                        3'd4: height_next = {cur_height[15:8], byte_value};
                        3'd5: width_next  = {byte_value, 8'h00};
                        3'd6: width_next  = {cur_width[15:8], byte_value};
                        3'd7: begin
                            hit        = 1'b1;
                            index_next = cur_index;
                            status     = (cur_seglen == {6'd0, sof_len}) ? ST_FOUND
                                                                         : ST_SOF_LEN;
                        end
                        default: ;
                    endcase
                end
                PH_SLEN: begin
                    if (cur_index == 3'd0) begin
                        seglen_next = {byte_value, 8'h00};
                        index_next  = 3'd1;
                    end else begin
                        seglen_next = full_len;
                        index_next  = 3'd0;
                        if (full_len < 16'd2) begin
                            hit    = 1'b1;
                            status = ST_SEG_SHORT;
                        end else begin
                            skip_next  = full_len - 16'd2;
                            phase_next = (full_len != 16'd2) ? PH_SKIP : PH_HUNT;
                        end
                    end
                end
                PH_SKIP: begin
                    if (cur_skip != 16'd0) begin
                        skip_next = cur_skip - 16'd1;
                    end
                    if (cur_skip <= 16'd1) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: ;
            endcase

            if (!hit && last_byte) begin
                hit    = 1'b1;
                status = ST_TRUNC;
            end
            if (hit) begin
                verdict_next = 1'b1;
            end
        end
    end

    assign stray_wide = WIDE_BITS'(stray_next);

    always_comb begin
        res_valid           = hit;
        res.status          = status;
        res.width           = (status == ST_FOUND) ? cur_width : 16'd0;
        res.height          = (status == ST_FOUND) ? cur_height : 16'd0;
        res.discarded_count = (stray_wide > WIDE_BITS'(17'h0FFFF)) ? 16'hFFFF
                                                                   : stray_wide[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_SOI0;
            index_reg       <= 3'd0;
            skip_reg        <= 16'd0;
            seglen_reg      <= 16'd0;
            height_reg      <= 16'd0;
            width_reg       <= 16'd0;
            stray_reg       <= '0;
            verdict_reg     <= 1'b0;
            allow_stray_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                allow_stray_reg <= cfg_allow_stray;
            end
            if (step) begin
                phase_reg   <= phase_next;
                index_reg   <= index_next;
                skip_reg    <= skip_next;
                seglen_reg  <= seglen_next;
                height_reg  <= height_next;
                width_reg   <= width_next;
                stray_reg   <= stray_next;
                verdict_reg <= verdict_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/jfs_out_reg.sv -----
// Result register with a one-entry skid buffer between the parser and the output channel.
// Depends on jfs_pkg for the result type.
`default_nettype none

module jfs_out_reg (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire jfs_pkg::jfs_result_t load_res,
    output logic                      can_accept,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output jfs_pkg::jfs_result_t      out_res
);
    import jfs_pkg::*;

    logic        valid_reg;
    jfs_result_t res_reg;
    logic        skid_valid_reg;
    jfs_result_t skid_reg;
    logic        main_free;

    assign main_free  = !valid_reg || out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_free) begin
            valid_reg      <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end else if (load) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_free) begin
            if (skid_valid_reg) begin
                res_reg <= skid_reg;
            end else if (load) begin
                res_reg <= load_res;
            end
        end
        if (load && !main_free) begin
            skid_reg <= load_res;
        end
    end

endmodule

`default_nettype wire
